/* rtl/cft_pkg.sv */
// Package for the CSV field tokenizer: request payload types, result kinds,
// parse modes and character constants. No dependencies.

package cft_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CELL   = 2'd1,
        KIND_RECORD = 2'd2
    } t_kind;

    typedef enum logic [4:0] {
        MODE_START    = 5'b00001,
        MODE_CELL     = 5'b00010,
        MODE_QUOTE    = 5'b00100,
        MODE_ENDLINE  = 5'b01000,
        MODE_ENDQUOTE = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } t_in_item;

    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] out_byte;
    } t_out_item;

endpackage

/* rtl/csv_field_tokenizer_top.sv */
// CSV field tokenizer: input request register, parser and result register.
// Depends on cft_pkg and cft_parser.
//
// Usage: each input request carries one text byte or an end-of-input mark.
// Each request gives zero or one result: a content byte (kind data), an end
// of cell, or an end of cell and record. Quoted fields, doubled quotes,
// blank-line collapsing and leading empty cells are handled in the parser.
// A request passes through the input register, the parse step and the result register, in that order.
// Throughput is one request per cycle, sustained while the receiver takes
// results; the single parse step between the two registers sets this rate.
// When the receiver stalls, the result register holds, the input register
// holds one more request, and o_in_ready falls. Requests that give no
// result pass through without occupying the result register.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the start of a cell with no cell stored.

module csv_field_tokenizer_top
    import cft_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;

    logic      w_adv;
    logic      w_step;
    logic      w_res_vld;
    t_out_item w_res;

    assign w_adv      = !r_out_vld || i_out_ready;
    assign w_step     = r_in_vld && w_adv;
    assign o_in_ready = !r_in_vld || w_adv;

    cft_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_item    (r_in),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_step && w_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // A non-data result never carries a byte.
    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.out_kind != KIND_DATA)) |-> (r_out.out_byte == 8'h00))
        else $error("close result carries a byte");

    // The parser steps only when the result register can take its output.
    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |-> (!r_out_vld || i_out_ready))
        else $error("parser stepped into a full result register");

    // A stalled result keeps the pending request in the input register.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_out_ready) |=> r_in_vld)
        else $error("pending request lost during a stall");

endmodule

/* rtl/cft_parser.sv */
// Parse state of the CSV tokenizer and the one-step transition logic.
// Depends on cft_pkg.

module cft_parser
    import cft_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output logic      o_res_vld,
    output t_out_item o_res
);

    t_mode r_mode;
    t_mode n_mode;
    logic  r_seen;
    logic  n_seen;
    logic  r_has;
    logic  n_has;

    logic w_line;
    logic w_comma;
    logic w_quote;
    logic w_close_ok;

    assign w_line     = (i_item.in_byte == CH_CR) || (i_item.in_byte == CH_LF);
    assign w_comma    = (i_item.in_byte == CH_COMMA);
    assign w_quote    = (i_item.in_byte == CH_QUOTE);
    assign w_close_ok = r_seen || r_has;

    always_comb begin
        n_mode    = r_mode;
        n_seen    = r_seen;
        n_has     = r_has;
        o_res_vld = 1'b0;
        o_res     = '{out_kind: KIND_DATA, out_byte: 8'h00};
        if (i_item.in_end) begin
            if (r_has) begin
                o_res_vld      = 1'b1;
                o_res.out_kind = KIND_CELL;
                n_seen         = 1'b1;
            end
            n_has  = 1'b0;
            n_mode = MODE_START;
        end else begin
            case (r_mode)
                MODE_QUOTE: begin
                    if (w_quote) begin
                        n_mode = MODE_ENDQUOTE;
                    end else begin
                        o_res_vld      = 1'b1;
                        o_res.out_byte = i_item.in_byte;
                        n_has          = 1'b1;
                    end
                end
                default: begin
                    if (w_line) begin
                        if (r_mode != MODE_ENDLINE) begin
                            n_mode = MODE_ENDLINE;
                            n_has  = 1'b0;
                            if (w_close_ok) begin
                                o_res_vld      = 1'b1;
                                o_res.out_kind = KIND_RECORD;
                                n_seen         = 1'b1;
                            end
                        end
                    end else if (w_comma) begin
                        n_mode = (r_mode == MODE_ENDLINE) ? MODE_ENDLINE : MODE_START;
                        n_has  = 1'b0;
                        if (w_close_ok) begin
                            o_res_vld      = 1'b1;
                            o_res.out_kind = KIND_CELL;
                            n_seen         = 1'b1;
                        end
                    end else if (w_quote && (r_mode != MODE_CELL)) begin
                        n_mode = MODE_QUOTE;
                        if (r_mode == MODE_ENDQUOTE) begin
                            o_res_vld      = 1'b1;
                            o_res.out_byte = CH_QUOTE;
                            n_has          = 1'b1;
                        end
                    end else begin
                        n_mode         = MODE_CELL;
                        o_res_vld      = 1'b1;
                        o_res.out_byte = i_item.in_byte;
                        n_has          = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_seen <= 1'b0;
            r_has  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_seen <= n_seen;
            r_has  <= n_has;
        end
    end

    // A cell that holds bytes is never in the start or after-record modes.
    a_has_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has |-> (r_mode != MODE_START) && (r_mode != MODE_ENDLINE))
        else $error("cell holds bytes in a mode between cells");

    // A close result marks that a cell has been stored.
    a_close_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_vld && (o_res.out_kind != KIND_DATA)) |=> r_seen)
        else $error("close result did not set the stored-cell flag");

    // A data result always leaves the cell non-empty.
    a_data_has: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_vld && (o_res.out_kind == KIND_DATA)) |=> r_has)
        else $error("data result left the cell empty");

    // Once a cell is stored the flag never clears before reset.
    a_seen_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |=> r_seen)
        else $error("stored-cell flag cleared");

endmodule
